/* hw/rtl/wadx_pkg.sv */
// wadx_pkg: shared types, constants and helpers for the adx stream unit
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps
`default_nettype none
package wadx_pkg;

  localparam int SUM_W  = 48;
  localparam int ACC_W  = 24;
  localparam int CNT_W  = 10;
  localparam int OUT_W  = 15;
  localparam int PER_W  = 8;
  localparam int DVD_W  = 64;
  localparam int DVS_W  = 50;
  localparam int DCNT_W = 7;

  localparam logic [CNT_W-1:0]  BARS_MAX     = 10'd1023;
  localparam logic [OUT_W-1:0]  DX_FULL      = 15'd25600;
  localparam logic [PER_W-1:0]  PERIOD_RESET = 8'd14;
  localparam logic [PER_W-1:0]  PERIOD_MIN   = 8'd2;

  // one classified bar handed from front to back
  typedef struct packed {
    logic             clr;
    logic [CNT_W-1:0] n;
    logic [SUM_W-1:0] tr;
    logic [SUM_W-1:0] pdm;
    logic [SUM_W-1:0] mdm;
  } bar_t;

  typedef struct packed {
    logic              start;
    logic [DVD_W-1:0]  dividend;
    logic [DVS_W-1:0]  divisor;
    logic [DCNT_W-1:0] count;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DVD_W-1:0] quotient;
  } div_rsp_t;

  typedef enum logic [3:0] {
    BK_IDLE, BK_CLEAR, BK_DSTART, BK_DWAIT, BK_UPD, BK_DXP, BK_DXS,
    BK_DXW, BK_ADX, BK_ADS, BK_ADW, BK_OUT
  } back_state_t;

  // saturating sum add
  function automatic logic [SUM_W-1:0] sat_sum(input logic [SUM_W-1:0] base,
                                               input logic [SUM_W-1:0] add);
    logic [SUM_W:0] s;
    s = {1'b0, base} + {1'b0, add};
    return s[SUM_W] ? {SUM_W{1'b1}} : s[SUM_W-1:0];
  endfunction

endpackage
`default_nettype wire

/* hw/rtl/wadx_div.sv */
// wadx_div: shared restoring divider, one quotient bit per cycle
// depends on wadx_pkg
`timescale 1ns / 1ps
`default_nettype none
module wadx_div (
  input  logic               clk,
  input  logic               rst,
  input  wadx_pkg::div_req_t req,
  output wadx_pkg::div_rsp_t rsp
);
  import wadx_pkg::*;

  logic              busy;
  logic              done;
  logic [DCNT_W-1:0] cnt;
  logic [DVS_W-1:0]  rem;
  logic [DVS_W-1:0]  dvs;
  logic [DVD_W-1:0]  dvd;
  logic [DVD_W-1:0]  quo;
  logic [DVS_W:0]    rem_sh;
  logic              fits;

  // trial subtract
  assign rem_sh = {rem, dvd[DVD_W-1]};
  assign fits   = rem_sh >= {1'b0, dvs};

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && (cnt == DCNT_W'(1));
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= req.count;
      end else if (busy) begin
        cnt <= cnt - DCNT_W'(1);
        if (cnt == DCNT_W'(1)) busy <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (req.start) begin
      rem <= '0;
      dvs <= req.divisor;
      dvd <= req.dividend;
      quo <= '0;
    end else if (busy) begin
      dvd <= {dvd[DVD_W-2:0], 1'b0};
      if (fits) begin
        rem <= DVS_W'(rem_sh - {1'b0, dvs});
        quo <= {quo[DVD_W-2:0], 1'b1};
      end else begin
        rem <= rem_sh[DVS_W-1:0];
        quo <= {quo[DVD_W-2:0], 1'b0};
      end
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = quo;

endmodule
`default_nettype wire

/* hw/rtl/wadx_front.sv */
// wadx_front: accepts bars, forms true range and directional moves
// depends on wadx_pkg
`timescale 1ns / 1ps
`default_nettype none
module wadx_front #(
  parameter int PRICE_WIDTH = 32
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [PRICE_WIDTH-1:0] bar_high,
  input  logic [PRICE_WIDTH-1:0] bar_low,
  input  logic [PRICE_WIDTH-1:0] bar_close,
  input  logic                   series_start,
  input  logic                   q_full,
  output logic                   push,
  output wadx_pkg::bar_t         entry
);
  import wadx_pkg::*;

  logic [PRICE_WIDTH-1:0] prev_high, prev_low, prev_close;
  logic [CNT_W-1:0]       bars_seen;
  logic [CNT_W-1:0]       n;

  logic signed [PRICE_WIDTH:0] d_hl, d_hc, d_lc, up, dn;
  logic [PRICE_WIDTH-1:0]      a_hc, a_lc, a_max, tr, pdm, mdm;

  assign in_stall = q_full;
  assign push     = in_valid && !q_full;
  assign n        = series_start ? '0 : bars_seen;

  // true range and directional movement
  always_comb begin
    d_hl  = $signed({1'b0, bar_high}) - $signed({1'b0, bar_low});
    d_hc  = $signed({1'b0, bar_high}) - $signed({1'b0, prev_close});
    d_lc  = $signed({1'b0, bar_low}) - $signed({1'b0, prev_close});
    up    = $signed({1'b0, bar_high}) - $signed({1'b0, prev_high});
    dn    = $signed({1'b0, prev_low}) - $signed({1'b0, bar_low});
    a_hc  = d_hc[PRICE_WIDTH] ? PRICE_WIDTH'(-d_hc) : d_hc[PRICE_WIDTH-1:0];
    a_lc  = d_lc[PRICE_WIDTH] ? PRICE_WIDTH'(-d_lc) : d_lc[PRICE_WIDTH-1:0];
    a_max = (a_hc > a_lc) ? a_hc : a_lc;
    if (d_hl[PRICE_WIDTH] || a_max > d_hl[PRICE_WIDTH-1:0]) tr = a_max;
    else tr = d_hl[PRICE_WIDTH-1:0];
    pdm = (up > dn && up > 0) ? up[PRICE_WIDTH-1:0] : '0;
    mdm = (dn > up && dn > 0) ? dn[PRICE_WIDTH-1:0] : '0;
  end

  assign entry.clr = series_start;
  assign entry.n   = n;
  assign entry.tr  = SUM_W'(tr);
  assign entry.pdm = SUM_W'(pdm);
  assign entry.mdm = SUM_W'(mdm);

  // previous bar and saturating bar count
  always_ff @(posedge clk) begin
    if (rst) begin
      bars_seen  <= '0;
      prev_high  <= '0;
      prev_low   <= '0;
      prev_close <= '0;
    end else if (push) begin
      prev_high  <= bar_high;
      prev_low   <= bar_low;
      prev_close <= bar_close;
      bars_seen  <= (n < BARS_MAX) ? n + CNT_W'(1) : n;
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/wadx_queue.sv */
// wadx_queue: two-entry queue of classified bars between front and back
// depends on wadx_pkg
`timescale 1ns / 1ps
`default_nettype none
module wadx_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  wadx_pkg::bar_t wr_data,
  output logic           full,
  input  logic           pop,
  output logic           rd_valid,
  output wadx_pkg::bar_t rd_data
);
  import wadx_pkg::*;

  bar_t       mem [2];
  logic       wp, rp;
  logic [1:0] cnt;

  assign full     = cnt == 2'd2;
  assign rd_valid = cnt != 2'd0;
  assign rd_data  = mem[rp];

  // storage
  always_ff @(posedge clk) begin
    if (push) mem[wp] <= wr_data;
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (push) wp <= ~wp;
      if (pop) rp <= ~rp;
      cnt <= cnt + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/wadx_back.sv */
// wadx_back: smoothing, directional index and adx sequencer with output register
// depends on wadx_pkg; drives the shared divider wadx_div
`timescale 1ns / 1ps
`default_nettype none
module wadx_back (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [wadx_pkg::PER_W-1:0]  period,
  input  logic                        q_valid,
  input  wadx_pkg::bar_t              q_data,
  output logic                        q_pop,
  output wadx_pkg::div_req_t          div_req,
  input  wadx_pkg::div_rsp_t          div_rsp,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [wadx_pkg::OUT_W-1:0]  adx_value,
  output logic [wadx_pkg::OUT_W-1:0]  dx_value,
  output logic                        adx_valid
);
  import wadx_pkg::*;

  back_state_t      state, state_next;
  bar_t             cur;
  logic [SUM_W-1:0] sum_r, sum_p, sum_m, q_r, q_p, q_m, sel_sum;
  logic [1:0]       sel;
  logic [OUT_W-1:0] dx, adx_r;
  logic             vld_r;
  logic [ACC_W-1:0] acc;
  logic [DVD_W-1:0] num;
  logic [SUM_W:0]   tot;
  logic [SUM_W-1:0] diff;
  logic [CNT_W-1:0] per_n, lim;
  logic             seeding, out_free;
  logic [ACC_W:0]   acc_add;
  logic [OUT_W-1:0] acc_clamp;

  assign per_n    = CNT_W'(period);
  assign lim      = CNT_W'({period, 1'b0}) - CNT_W'(1);
  assign seeding  = cur.n <= per_n;
  assign out_free = !out_valid || !out_stall;
  assign tot      = {1'b0, sum_p} + {1'b0, sum_m};
  assign diff     = (sum_p > sum_m) ? sum_p - sum_m : sum_m - sum_p;
  assign acc_add  = {1'b0, acc} + (ACC_W+1)'(dx);
  assign acc_clamp = (acc > ACC_W'(DX_FULL)) ? DX_FULL : acc[OUT_W-1:0];

  always_comb begin
    case (sel)
      2'd0:    sel_sum = sum_r;
      2'd1:    sel_sum = sum_p;
      default: sel_sum = sum_m;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) state <= BK_IDLE;
    else state <= state_next;
  end

  // next state, queue pop and divider requests
  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    div_req    = '0;
    case (state)
      BK_IDLE: begin
        if (q_valid) begin
          q_pop      = 1'b1;
          state_next = BK_CLEAR;
        end
      end
      BK_CLEAR: begin
        if (cur.n == '0) state_next = BK_OUT;
        else if (seeding) state_next = BK_UPD;
        else state_next = BK_DSTART;
      end
      BK_DSTART: begin
        div_req.start    = 1'b1;
        div_req.dividend = {sel_sum, {(DVD_W-SUM_W){1'b0}}};
        div_req.divisor  = DVS_W'(period);
        div_req.count    = DCNT_W'(SUM_W);
        state_next       = BK_DWAIT;
      end
      BK_DWAIT: begin
        if (div_rsp.done) state_next = (sel == 2'd2) ? BK_UPD : BK_DSTART;
      end
      BK_UPD: begin
        state_next = (cur.n >= per_n) ? BK_DXP : BK_OUT;
      end
      BK_DXP: begin
        state_next = (sum_r == '0 || tot == '0) ? BK_ADX : BK_DXS;
      end
      BK_DXS: begin
        div_req.start    = 1'b1;
        div_req.dividend = num;
        div_req.divisor  = DVS_W'(tot);
        div_req.count    = DCNT_W'(DVD_W);
        state_next       = BK_DXW;
      end
      BK_DXW: begin
        if (div_rsp.done) state_next = BK_ADX;
      end
      BK_ADX: begin
        if (cur.n <= lim) state_next = (cur.n == lim) ? BK_ADS : BK_OUT;
        else state_next = BK_ADS;
      end
      BK_ADS: begin
        div_req.start    = 1'b1;
        div_req.dividend = {acc, {(DVD_W-ACC_W){1'b0}}};
        div_req.divisor  = DVS_W'(period);
        div_req.count    = DCNT_W'(ACC_W);
        state_next       = BK_ADW;
      end
      BK_ADW: begin
        if (div_rsp.done) state_next = BK_OUT;
      end
      BK_OUT: begin
        if (out_free) state_next = BK_IDLE;
      end
      default: state_next = BK_IDLE;
    endcase
  end

  // working registers, sums and accumulator start from zero
  always_ff @(posedge clk) begin
    if (rst) begin
      sum_r <= '0;
      sum_p <= '0;
      sum_m <= '0;
      acc   <= '0;
    end else begin
      case (state)
        BK_IDLE: begin
          if (q_valid) cur <= q_data;
          sel <= 2'd0;
        end
        BK_CLEAR: begin
          if (cur.clr) begin
            sum_r <= '0;
            sum_p <= '0;
            sum_m <= '0;
            acc   <= '0;
          end
          dx    <= '0;
          adx_r <= '0;
          vld_r <= 1'b0;
        end
        BK_DWAIT: begin
          if (div_rsp.done) begin
            case (sel)
              2'd0:    q_r <= div_rsp.quotient[SUM_W-1:0];
              2'd1:    q_p <= div_rsp.quotient[SUM_W-1:0];
              default: q_m <= div_rsp.quotient[SUM_W-1:0];
            endcase
            sel <= sel + 2'd1;
          end
        end
        BK_UPD: begin
          if (seeding) begin
            sum_r <= sat_sum(sum_r, cur.tr);
            sum_p <= sat_sum(sum_p, cur.pdm);
            sum_m <= sat_sum(sum_m, cur.mdm);
          end else begin
            sum_r <= sat_sum(sum_r - q_r, cur.tr);
            sum_p <= sat_sum(sum_p - q_p, cur.pdm);
            sum_m <= sat_sum(sum_m - q_m, cur.mdm);
          end
        end
        // diff * 25600 as shifted adds
        BK_DXP: begin
          num <= (DVD_W'(diff) << 14) + (DVD_W'(diff) << 13) + (DVD_W'(diff) << 10);
        end
        BK_DXW: begin
          if (div_rsp.done) dx <= div_rsp.quotient[OUT_W-1:0];
        end
        BK_ADX: begin
          if (cur.n <= lim) acc <= acc_add[ACC_W] ? {ACC_W{1'b1}} : acc_add[ACC_W-1:0];
          else acc <= ACC_W'(acc_clamp) * ACC_W'(period - PER_W'(1)) + ACC_W'(dx);
        end
        BK_ADW: begin
          if (div_rsp.done) begin
            acc   <= div_rsp.quotient[ACC_W-1:0];
            adx_r <= div_rsp.quotient[OUT_W-1:0];
            vld_r <= 1'b1;
          end
        end
        BK_OUT: begin
          if (out_free) begin
            adx_value <= adx_r;
            dx_value  <= dx;
            adx_valid <= vld_r;
          end
        end
        default: ;
      endcase
    end
  end

  // output register valid
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (state == BK_OUT && out_free) out_valid <= 1'b1;
    else if (!out_stall) out_valid <= 1'b0;
  end

`ifndef SYNTHESIS
  a_pop_idle: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> state == BK_IDLE) else $error("queue popped outside idle");
  a_dx_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> dx_value <= DX_FULL) else $error("dx above full scale");
  a_adx_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !adx_valid) |-> adx_value == '0) else $error("adx set while not valid");
  a_div_start: assert property (@(posedge clk) disable iff (rst)
    div_req.start |=> !div_rsp.done) else $error("divider done right after start");
`endif

endmodule
`default_nettype wire

/* hw/rtl/wilder_adx_stream_unit.sv */
// wilder_adx_stream_unit: streaming wilder adx, top level
// depends on wadx_pkg, wadx_front, wadx_queue, wadx_back, wadx_div
//
// usage:
//   input channel: in_valid/in_stall with bar_high, bar_low, bar_close and
//   series_start; a transaction is taken when in_valid is high and in_stall low.
//   output channel: out_valid/out_stall with adx_value, dx_value, adx_valid;
//   one result transaction per bar, in bar order.
//   config channel: cfg_valid/cfg_ready with cfg_data (smoothing period);
//   cfg_ready is always high, write only while the block is idle.
// flow:
//   the front passes each bar into a two-entry queue; the back works one bar
//   at a time through a shared one-bit-per-cycle divider. a first bar goes to
//   the output; bars up to the period add to the sums; from the period on, dx
//   is divided out, a smoothed bar first divides the three sums by the period.
// reset: rst clears counts, sums, queue and output valid; period returns to 14.
// stall: a result waits in the output register; the queue keeps taking bars
//   until it holds two, then in_stall rises.
`timescale 1ns / 1ps
`default_nettype none
module wilder_adx_stream_unit #(
  parameter int PRICE_WIDTH = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [wadx_pkg::PER_W-1:0]    cfg_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [PRICE_WIDTH-1:0]        bar_high,
  input  logic [PRICE_WIDTH-1:0]        bar_low,
  input  logic [PRICE_WIDTH-1:0]        bar_close,
  input  logic                          series_start,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [wadx_pkg::OUT_W-1:0]    adx_value,
  output logic [wadx_pkg::OUT_W-1:0]    dx_value,
  output logic                          adx_valid
);
  import wadx_pkg::*;

  logic [PER_W-1:0] period_reg, period;
  logic             push, q_full, q_pop, q_valid;
  bar_t             entry, q_data;
  div_req_t         div_req;
  div_rsp_t         div_rsp;

  // period register, values below two act as two
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) period_reg <= PERIOD_RESET;
    else if (cfg_valid && cfg_ready) period_reg <= cfg_data;
  end
  assign period = (period_reg < PERIOD_MIN) ? PERIOD_MIN : period_reg;

  wadx_front #(.PRICE_WIDTH(PRICE_WIDTH)) u_front (
    .clk, .rst, .in_valid, .in_stall, .bar_high, .bar_low, .bar_close,
    .series_start, .q_full, .push, .entry
  );

  wadx_queue u_queue (
    .clk, .rst, .push, .wr_data(entry), .full(q_full), .pop(q_pop),
    .rd_valid(q_valid), .rd_data(q_data)
  );

  wadx_div u_div (.clk, .rst, .req(div_req), .rsp(div_rsp));

  wadx_back u_back (
    .clk, .rst, .period, .q_valid, .q_data, .q_pop, .div_req, .div_rsp,
    .out_valid, .out_stall, .adx_value, .dx_value, .adx_valid
  );

endmodule
`default_nettype wire
